FILE: rtl/prsd_pkg.sv
// Shared types and constants for the palette run sprite decoder.
// No dependencies; imported by the parser, top level, checker and testbench.
package prsd_pkg;

   // Stream channel widths (bits).
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 152;

   // req_tuser: what the input transfer carries.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_STREAM  = 1'b1;

   // rsp_tuser: result kind.
   localparam logic [1:0] KIND_PIXEL  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   // Run word that closes a frame.
   localparam logic [31:0] END_WORD = 32'h7FFF_7FFF;

   // One parsed event: result kind, pixel coordinates and header values.
   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] pix_x;
      logic [17:0] pix_y;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] center_x;
      logic [15:0] center_y;
   } evt_type;

endpackage

FILE: rtl/prsd_parser.sv
// Frame stream parser: header bytes, run words and pixel bytes.
// Depends on prsd_pkg for evt_type, the kind codes and END_WORD.
module prsd_parser import prsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       byte_valid,
   input  logic [7:0] data_byte,
   output logic       evt_valid,
   output evt_type    evt
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_WORD   = 2'd1;
   localparam logic [1:0] PH_PIXELS = 2'd2;

   logic [1:0]  phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [23:0] word_ff, word_in;
   logic [15:0] cx_ff, cx_in;
   logic [15:0] cy_ff, cy_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [9:0]  xo_ff, xo_in;
   logic [9:0]  yo_ff, yo_in;
   logic [11:0] left_ff, left_in;
   logic [11:0] rpos_ff, rpos_in;

   logic [31:0] full_word;
   logic [16:0] pix_x;
   logic [17:0] pix_y;

   assign full_word = {data_byte, word_ff};

   assign pix_x = {cx_ff[15], cx_ff} + {{7{xo_ff[9]}}, xo_ff} + {5'b0, rpos_ff};
   assign pix_y = {{2{cy_ff[15]}}, cy_ff} + {{8{yo_ff[9]}}, yo_ff} + {2'b0, height_ff};

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      word_in   = word_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      width_in  = width_ff;
      height_in = height_ff;
      xo_in     = xo_ff;
      yo_in     = yo_ff;
      left_in   = left_ff;
      rpos_in   = rpos_ff;
      evt_valid = 1'b0;
      evt.kind  = KIND_PIXEL;
      if (byte_valid) begin
         unique case (phase_ff)
            PH_HEADER: begin
               // Little-endian header: x, y, width, height.
               case (pos_ff[2:1])
                  2'd0: if (pos_ff[0]) cx_in[15:8] = data_byte;
                        else cx_in[7:0] = data_byte;
                  2'd1: if (pos_ff[0]) cy_in[15:8] = data_byte;
                        else cy_in[7:0] = data_byte;
                  2'd2: if (pos_ff[0]) width_in[15:8] = data_byte;
                        else width_in[7:0] = data_byte;
                  default: if (pos_ff[0]) height_in[15:8] = data_byte;
                           else height_in[7:0] = data_byte;
               endcase
               if (pos_ff == 3'd7) begin
                  pos_in    = 3'd0;
                  word_in   = 24'd0;
                  phase_in  = PH_WORD;
                  evt_valid = 1'b1;
                  evt.kind  = KIND_HEADER;
               end else begin
                  pos_in = pos_ff + 3'd1;
               end
            end
            PH_WORD: begin
               case (pos_ff[1:0])
                  2'd0: word_in[7:0]   = data_byte;
                  2'd1: word_in[15:8]  = data_byte;
                  2'd2: word_in[23:16] = data_byte;
                  default: ;
               endcase
               if (pos_ff[1:0] != 2'd3) begin
                  pos_in = {1'b0, pos_ff[1:0] + 2'd1};
               end else begin
                  pos_in = 3'd0;
                  if (full_word == END_WORD) begin
                     word_in   = 24'd0;
                     phase_in  = PH_HEADER;
                     evt_valid = 1'b1;
                     evt.kind  = KIND_END;
                  end else begin
                     xo_in   = full_word[31:22];
                     yo_in   = full_word[21:12];
                     left_in = full_word[11:0];
                     rpos_in = 12'd0;
                     // Zero-length run: stay and take the next word.
                     if (full_word[11:0] != 12'd0) phase_in = PH_PIXELS;
                  end
               end
            end
            default: begin
               // Pixel byte; the unused phase code behaves the same.
               evt_valid = 1'b1;
               evt.kind  = KIND_PIXEL;
               rpos_in   = rpos_ff + 12'd1;
               left_in   = left_ff - 12'd1;
               if (left_in == 12'd0) begin
                  phase_in = PH_WORD;
                  pos_in   = 3'd0;
                  word_in  = 24'd0;
               end
            end
         endcase
      end
      evt.pix_x    = pix_x;
      evt.pix_y    = pix_y;
      evt.width    = width_in;
      evt.height   = height_in;
      evt.center_x = cx_in;
      evt.center_y = cy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= 3'd0;
         word_ff   <= 24'd0;
         cx_ff     <= 16'd0;
         cy_ff     <= 16'd0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         xo_ff     <= 10'd0;
         yo_ff     <= 10'd0;
         left_ff   <= 12'd0;
         rpos_ff   <= 12'd0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         word_ff   <= word_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         xo_ff     <= xo_in;
         yo_ff     <= yo_in;
         left_ff   <= left_in;
         rpos_ff   <= rpos_in;
      end
   end

endmodule

FILE: rtl/palette_run_sprite_decoder_core.sv
// Top level of the palette run sprite decoder: palette memory, pipeline, ports.
// Depends on prsd_pkg and prsd_parser.
//
// Usage:
//  - Input channel req_*: each transfer is either a palette write (req_tuser =
//    OP_PALETTE, index and color in req_tdata) or one frame stream byte
//    (req_tuser = OP_STREAM, byte in req_tdata[31:24]).
//  - A frame is an 8-byte header, then 32-bit run words each followed by its
//    pixel bytes; the word 0x7FFF7FFF closes the frame.
//  - Result channel rsp_*: one transfer per header, per pixel byte and per
//    frame end; rsp_tuser gives the kind. Palette writes, header bytes 0..6
//    and run word bytes produce nothing.
//  - Throughput: one input transfer per cycle, sustained while rsp_tready is high.
//  - Pipeline: a result passes from stage 1 into the output register. Stage 1
//    holds the parse result and the registered palette read; stage 2 does the
//    row-major multiply-add and bounds check into the output register.
//  - Stall: while rsp_tready is low the pipeline still fills its empty stages;
//    req_tready drops only once both stages hold a result.
//  - Reset clears the parser to header phase and empties the pipeline; the
//    palette keeps its contents, and an entry must be written before a pixel
//    byte selects it.
module palette_run_sprite_decoder_core import prsd_pkg::*; #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] palette_index, [23:8] palette_color, [31:24] data_byte
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [16:0] pixel_x, [34:17] pixel_y, [66:35] address, [82:67] color,
   // [83] in_bounds, [99:84] frame_width, [115:100] frame_height,
   // [131:116] center_x, [147:132] center_y, [151:148] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] kind
   output logic [1:0]            rsp_tuser
);

   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   logic [15:0] palette_mem [PALETTE_ENTRIES];

   logic [7:0]  req_index;
   logic [15:0] req_color;
   logic [7:0]  req_byte;
   logic        req_fire;
   logic        pal_wr;
   logic        stream_fire;

   logic        evt_valid;
   evt_type     evt;

   logic        s1_en;
   logic        out_en;
   logic        s1_valid_ff;
   evt_type     s1_evt_ff;
   logic [15:0] s1_color_ff;
   logic        s1_hit_ff;

   logic signed [34:0] prod;
   logic [31:0] addr;
   logic        x_in;
   logic        y_in;
   logic [15:0] color;
   logic [RSP_DATA_W-1:0] rsp_data_in;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_kind_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   assign req_index = req_tdata[7:0];
   assign req_color = req_tdata[23:8];
   assign req_byte  = req_tdata[31:24];

   // Advance each stage when its successor can take it.
   assign out_en      = !rsp_valid_ff || rsp_tready;
   assign s1_en       = !s1_valid_ff || out_en;
   assign req_tready  = s1_en;
   assign req_fire    = req_tvalid && req_tready;
   assign stream_fire = req_fire && (req_tuser == OP_STREAM);
   // Drop writes to entries the palette does not have.
   assign pal_wr = req_fire && (req_tuser == OP_PALETTE)
                   && ({1'b0, req_index} < 9'(PALETTE_ENTRIES));

   always_ff @(posedge clock) begin
      if (pal_wr) begin
         palette_mem[req_index[PAL_AW-1:0]] <= req_color;
      end
   end

   prsd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (stream_fire),
      .data_byte  (req_byte),
      .evt_valid  (evt_valid),
      .evt        (evt)
   );

   // Stage 1: parse result and palette read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= evt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_evt_ff   <= evt;
         s1_color_ff <= palette_mem[req_byte[PAL_AW-1:0]];
         s1_hit_ff   <= ({1'b0, req_byte} < 9'(PALETTE_ENTRIES));
      end
   end

   // Stage 2: address = y * width + x, wrapped to 32 bits; bounds check.
   assign prod = $signed(s1_evt_ff.pix_y) * $signed({1'b0, s1_evt_ff.width});
   assign addr = prod[31:0] + {{15{s1_evt_ff.pix_x[16]}}, s1_evt_ff.pix_x};
   assign x_in = !s1_evt_ff.pix_x[16]
                 && ($signed({s1_evt_ff.pix_x[16], s1_evt_ff.pix_x})
                     < $signed({2'b00, s1_evt_ff.width}));
   assign y_in = !s1_evt_ff.pix_y[17]
                 && ($signed(s1_evt_ff.pix_y) < $signed({2'b00, s1_evt_ff.height}));
   assign color = s1_hit_ff ? s1_color_ff : 16'd0;

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[99:84]   = s1_evt_ff.width;
      rsp_data_in[115:100] = s1_evt_ff.height;
      rsp_data_in[131:116] = s1_evt_ff.center_x;
      rsp_data_in[147:132] = s1_evt_ff.center_y;
      // Header and end results carry zero pixel fields.
      if (s1_evt_ff.kind == KIND_PIXEL) begin
         rsp_data_in[16:0]  = s1_evt_ff.pix_x;
         rsp_data_in[34:17] = s1_evt_ff.pix_y;
         rsp_data_in[66:35] = addr;
         rsp_data_in[82:67] = color;
         rsp_data_in[83]    = x_in && y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_kind_ff <= s1_evt_ff.kind;
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/prsd_checker.sv
// Port-level checks on the result channel of the sprite decoder, and the bind.
// Depends on prsd_pkg and palette_run_sprite_decoder_core.
module prsd_checker import prsd_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_PIXEL || rsp_tuser == KIND_HEADER
                      || rsp_tuser == KIND_END))
      else $error("result kind out of range");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[151:148] == 4'd0)
      else $error("padding bits not zero");

   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_PIXEL |-> rsp_tdata[83:0] == 84'd0)
      else $error("header or end result carries pixel fields");

   a_bounds_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[83] |-> !rsp_tdata[16] && !rsp_tdata[34])
      else $error("in-bounds pixel with negative coordinate");

endmodule

bind palette_run_sprite_decoder_core prsd_checker u_prsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

FILE: test/tb_palette_run_sprite_decoder_core.sv
// Self-checking testbench for palette_run_sprite_decoder_core: palette loads,
// frame headers, run words and pixel bytes, checked against a built-in decoder.
// Depends on prsd_pkg and the decoder RTL; needs no other files.
module tb_palette_run_sprite_decoder_core;
   timeunit 1ns;
   timeprecision 1ps;

   import prsd_pkg::*;

   localparam int PALETTE_ENTRIES = 256;
   localparam int RANDOM_ITEMS    = 500;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;

   // One decoder event as it leaves on rsp_*.
   typedef struct packed {
      logic [1:0]  kind;
      logic [16:0] pix_x;
      logic [17:0] pix_y;
      logic [31:0] addr;
      logic [15:0] color;
      logic        in_bounds;
      logic [15:0] width;
      logic [15:0] height;
      logic [15:0] center_x;
      logic [15:0] center_y;
   } decoded_type;

   // One row of the directed stimulus; typed rows carry their result by hand.
   typedef struct packed {
      logic        op;
      logic [7:0]  index;
      logic [15:0] color;
      logic [7:0]  data;
      logic        typed;
      decoded_type result;
   } step_row_type;

   typedef enum logic [1:0] {
      HDR_PHASE,
      WORD_PHASE,
      PIXEL_PHASE
   } parse_phase_type;

   localparam decoded_type NO_EVENT = '0;
   // Header with every field at an extreme: min x, max y, max width and height.
   localparam decoded_type HDR_EXTREME = '{KIND_HEADER, 17'd0, 18'd0, 32'd0, 16'd0, 1'b0,
                                           16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF};
   localparam decoded_type END_EXTREME = '{KIND_END, 17'd0, 18'd0, 32'd0, 16'd0, 1'b0,
                                           16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF};

   // Directed frame: palette extremes, extreme header, a run of two pixels at the
   // lowest x offset and highest y offset (both outside the frame), a zero-length
   // run, a palette write in the middle of the frame, then the end word.
   localparam int DIRECTED_ROWS = 25;
   localparam step_row_type DIRECTED [0:DIRECTED_ROWS-1] = '{
      '{OP_PALETTE, 8'h00, 16'hFFFF, 8'h00, 1'b0, NO_EVENT},
      '{OP_PALETTE, 8'hFF, 16'h0001, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h80, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h7F, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b1, HDR_EXTREME},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h02, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hF0, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h1F, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h80, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h00, 1'b0, NO_EVENT},
      '{OP_PALETTE, 8'h80, 16'h5A5A, 8'h00, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h7F, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'hFF, 1'b0, NO_EVENT},
      '{OP_STREAM,  8'h00, 16'h0000, 8'h7F, 1'b1, END_EXTREME}
   };

   // DUT ports; every input starts at a known value.
   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = OP_PALETTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;

   // Decoder copy kept by the testbench.
   logic [15:0]     palette_mem [PALETTE_ENTRIES];
   bit              palette_set [PALETTE_ENTRIES];
   logic [7:0]      written_idx [$];
   parse_phase_type phase    = HDR_PHASE;
   int              byte_pos = 0;
   logic [31:0]     word_acc = '0;
   logic [15:0]     hdr_cx = '0, hdr_cy = '0, hdr_w = '0, hdr_h = '0;
   logic [9:0]      run_xo = '0, run_yo = '0;
   logic [11:0]     run_left = '0, run_pos = '0;

   decoded_type decoded_q [$];

   int  cycle_count    = 0;
   int  mismatch_count = 0;
   int  items_accepted = 0;
   int  palette_writes = 0;
   int  headers_seen   = 0;
   int  ends_seen      = 0;
   int  pixels_seen    = 0;
   int  pixels_inside  = 0;
   int  stall_left     = 0;
   // While calm is high no new gaps or stalls begin.
   logic calm = 1'b0;
   decoded_type got_event;

   palette_run_sprite_decoder_core #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the decoder copy by one stream byte; return 1 if it yields an event.
   function automatic bit decode_byte(input logic [7:0] b, output decoded_type ev);
      bit produced;
      int x, y;
      produced = 1'b0;
      ev = '0;
      case (phase)
         HDR_PHASE: begin
            case (byte_pos)
               0: hdr_cx[7:0]  = b;
               1: hdr_cx[15:8] = b;
               2: hdr_cy[7:0]  = b;
               3: hdr_cy[15:8] = b;
               4: hdr_w[7:0]   = b;
               5: hdr_w[15:8]  = b;
               6: hdr_h[7:0]   = b;
               default: hdr_h[15:8] = b;
            endcase
            if (byte_pos == 7) begin
               byte_pos = 0;
               word_acc = '0;
               phase    = WORD_PHASE;
               ev.kind  = KIND_HEADER;
               produced = 1'b1;
            end else begin
               byte_pos++;
            end
         end
         WORD_PHASE: begin
            word_acc[byte_pos*8 +: 8] = b;
            if (byte_pos != 3) begin
               byte_pos++;
            end else begin
               byte_pos = 0;
               if (word_acc == END_WORD) begin
                  word_acc = '0;
                  phase    = HDR_PHASE;
                  ev.kind  = KIND_END;
                  produced = 1'b1;
               end else begin
                  run_xo   = word_acc[31:22];
                  run_yo   = word_acc[21:12];
                  run_left = word_acc[11:0];
                  run_pos  = '0;
                  // A zero-length run goes straight on to the next run word.
                  if (run_left != 0) phase = PIXEL_PHASE;
               end
            end
         end
         default: begin
            x = int'($signed(hdr_cx)) + int'($signed(run_xo)) + int'(run_pos);
            y = int'($signed(hdr_cy)) + int'($signed(run_yo)) + int'(hdr_h);
            ev.kind      = KIND_PIXEL;
            ev.pix_x     = 17'(x);
            ev.pix_y     = 18'(y);
            ev.addr      = 32'(y * int'(hdr_w) + x);
            ev.color     = (int'(b) < PALETTE_ENTRIES) ? palette_mem[b] : 16'h0000;
            ev.in_bounds = (x >= 0 && x < int'(hdr_w) && y >= 0 && y < int'(hdr_h));
            produced     = 1'b1;
            run_pos++;
            run_left--;
            if (run_left == 0) begin
               phase    = WORD_PHASE;
               byte_pos = 0;
               word_acc = '0;
            end
         end
      endcase
      if (produced) begin
         ev.width    = hdr_w;
         ev.height   = hdr_h;
         ev.center_x = hdr_cx;
         ev.center_y = hdr_cy;
      end
      return produced;
   endfunction

   // Present one item, hold it until the transfer, then predict what it causes.
   task automatic send_item(input logic op, input logic [7:0] index,
                            input logic [15:0] color, input logic [7:0] data,
                            input logic typed, input decoded_type typed_event);
      decoded_type predicted;
      bit          has_event;
      if (!calm && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         repeat (gap_len()) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {data, color, index};
      // Handshake signals read here still hold their pre-edge values.
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      has_event = 1'b0;
      if (op == OP_PALETTE) begin
         palette_writes++;
         if (int'(index) < PALETTE_ENTRIES) begin
            palette_mem[index] = color;
            if (!palette_set[index]) begin
               palette_set[index] = 1'b1;
               written_idx.push_back(index);
            end
         end
      end else begin
         has_event = decode_byte(data, predicted);
      end
      if (has_event) decoded_q.push_back(typed ? typed_event : predicted);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Cycle counter, calm stretches and the hard stop.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 255) calm <= ($urandom_range(0, 3) == 0);
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, decoded_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Result side: check each transfer against the oldest prediction, then
   // drive rsp_tready for the next cycle with random stalls.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (decoded_q.size() == 0) begin
            $error("result of kind %0d with no prediction waiting", rsp_tuser);
            mismatch_count++;
         end else begin
            got_event = decoded_q.pop_front();
            check_field("kind",         got_event.kind,      rsp_tuser);
            check_field("pixel_x",      got_event.pix_x,     rsp_tdata[16:0]);
            check_field("pixel_y",      got_event.pix_y,     rsp_tdata[34:17]);
            check_field("address",      got_event.addr,      rsp_tdata[66:35]);
            check_field("color",        got_event.color,     rsp_tdata[82:67]);
            check_field("in_bounds",    got_event.in_bounds, rsp_tdata[83]);
            check_field("frame_width",  got_event.width,     rsp_tdata[99:84]);
            check_field("frame_height", got_event.height,    rsp_tdata[115:100]);
            check_field("center_x",     got_event.center_x,  rsp_tdata[131:116]);
            check_field("center_y",     got_event.center_y,  rsp_tdata[147:132]);
            check_field("zero pad",     32'd0,               rsp_tdata[151:148]);
            case (got_event.kind)
               KIND_HEADER: headers_seen++;
               KIND_END:    ends_seen++;
               default: begin
                  pixels_seen++;
                  if (got_event.in_bounds) pixels_inside++;
               end
            endcase
         end
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         stall_left = gap_len() - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Stimulus: reset, the directed frame, then random frames.
   initial begin
      logic [7:0]  plan_q [$];
      logic [15:0] w, h, cx, cy;
      logic [31:0] word;
      int          r, len;
      logic [9:0]  xo, yo;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i])
         send_item(DIRECTED[i].op, DIRECTED[i].index, DIRECTED[i].color,
                   DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].result);

      // Mostly well-formed frames with random content; palette writes as noise.
      // Pixel bytes only ever select entries that have been written.
      while (items_accepted < DIRECTED_ROWS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 8) begin
            send_item(OP_PALETTE, 8'($urandom), 16'($urandom), 8'($urandom),
                      1'b0, NO_EVENT);
         end else begin
            if (plan_q.size() == 0) begin
               case (phase)
                  HDR_PHASE: begin
                     if ($urandom_range(0, 99) < 70) begin
                        // Small frame placed so that many pixels land inside it.
                        w  = 16'($urandom_range(1, 20));
                        h  = 16'($urandom_range(1, 20));
                        cx = 16'($urandom_range(0, 6));
                        cy = 16'($urandom_range(0, 6) - h);
                     end else begin
                        w  = 16'($urandom);
                        h  = 16'($urandom);
                        cx = 16'($urandom);
                        cy = 16'($urandom);
                     end
                     plan_q = '{cx[7:0], cx[15:8], cy[7:0], cy[15:8],
                                w[7:0], w[15:8], h[7:0], h[15:8]};
                  end
                  WORD_PHASE: begin
                     r = $urandom_range(0, 99);
                     len = (r < 15) ? 0 :
                           (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 48);
                     if ($urandom_range(0, 99) < 75) begin
                        xo = 10'($urandom_range(0, 12) - 4);
                        yo = 10'($urandom_range(0, 8) - 4);
                     end else begin
                        xo = 10'($urandom);
                        yo = 10'($urandom);
                     end
                     // Run length stays short, so no run word can match the end word.
                     word = ($urandom_range(0, 99) < 10) ? END_WORD : {xo, yo, 12'(len)};
                     plan_q = '{word[7:0], word[15:8], word[23:16], word[31:24]};
                  end
                  default:
                     plan_q.push_back(written_idx[$urandom_range(0, written_idx.size() - 1)]);
               endcase
            end
            send_item(OP_STREAM, 8'($urandom), 16'($urandom), plan_q.pop_front(),
                      1'b0, NO_EVENT);
         end
      end

      // Drop valid, drain the pipeline, then let the output run on idle.
      req_tvalid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d transfers (%0d palette writes) over %0d cycles.",
               items_accepted, palette_writes, cycle_count);
      $display("Checked %0d headers, %0d frame ends and %0d pixels, %0d inside the frame.",
               headers_seen, ends_seen, pixels_seen, pixels_inside);
      if (mismatch_count == 0 && decoded_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/prsd_pkg.sv
rtl/prsd_parser.sv
rtl/palette_run_sprite_decoder_core.sv
rtl/prsd_checker.sv
test/tb_palette_run_sprite_decoder_core.sv
